// File: rtl/srl_pkg.sv
// Shared definitions for the setpoint ramp limiter.
// Holds the configuration register indexes and the delay counter width.
// No dependencies.
package srl_pkg;

   // Configuration register index
   typedef logic [1:0] csr_index_type;

   localparam csr_index_type REG_STEP_SIZE   = 2'd0;
   localparam csr_index_type REG_DELAY_LIMIT = 2'd1;
   localparam csr_index_type REG_LOWER_CLAMP = 2'd2;
   localparam csr_index_type REG_UPPER_CLAMP = 2'd3;

   // The delay counter and its limit are always 16 bits wide
   localparam int CNT_WIDTH = 16;

   typedef logic [CNT_WIDTH-1:0] count_type;

   localparam count_type CNT_MAX = '1;

endpackage

// File: rtl/setpoint_ramp_limiter_top.sv
// Setpoint ramp limiter, top level: input register, step logic, result register.
// Depends on srl_pkg, srl_csr and srl_step.
//
// Each accepted item carries a target value and yields exactly one result item:
// the setpoint after this tick and the at-target flag. The block accepts one
// item per clock cycle while the result is not stalled; the item waits in the
// input register until the result register is free, then the step logic loads
// the result register, which offers the result. The rate is set by the loop
// from the setpoint register through the gap compare, step add and clamp back
// into the setpoint register. A stalled result holds the item in the input
// register; once both are full, the input is ready only in cycles where the
// result is taken.
// Configuration registers are written through the csr_ port and take effect
// for items processed after the write.
module setpoint_ramp_limiter_top
   import srl_pkg::*;
#(
   parameter int VALUE_WIDTH = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [VALUE_WIDTH-1:0]           req_target_in,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [VALUE_WIDTH-1:0]           rsp_setpoint_out,
   output logic                                    rsp_at_target,
   input  logic                                    csr_wr_en,
   input  csr_index_type                           csr_index,
   input  logic [((VALUE_WIDTH > CNT_WIDTH) ? VALUE_WIDTH : CNT_WIDTH)-1:0] csr_wdata
);

   localparam int CSR_WIDTH = (VALUE_WIDTH > CNT_WIDTH) ? VALUE_WIDTH : CNT_WIDTH;

   logic [VALUE_WIDTH-2:0]        step_size;
   count_type                     delay_limit;
   logic signed [VALUE_WIDTH-1:0] lower_clamp;
   logic signed [VALUE_WIDTH-1:0] upper_clamp;

   logic                          in_valid_ff;
   logic                          in_valid_in;
   logic signed [VALUE_WIDTH-1:0] target_ff;

   logic                          out_valid_ff;
   logic                          out_valid_in;
   logic signed [VALUE_WIDTH-1:0] setpoint_ff;
   logic signed [VALUE_WIDTH-1:0] setpoint_in;
   count_type                     delay_count_ff;
   count_type                     delay_count_in;
   logic                          equal_mark_ff;
   logic                          equal_mark_in;

   logic                          advance;
   logic                          req_fire;

   // Configuration registers
   srl_csr #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .CSR_WIDTH   (CSR_WIDTH)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .step_size   (step_size),
      .delay_limit (delay_limit),
      .lower_clamp (lower_clamp),
      .upper_clamp (upper_clamp)
   );

   // Flow control: the held item moves on when the result register is free.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   assign in_valid_in  = req_fire ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : ((out_valid_ff && rsp_ready) ? 1'b0 : out_valid_ff);

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         target_ff <= req_target_in;
      end
   end

   // Step logic for the item in the input register
   srl_step #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_step (
      .target           (target_ff),
      .setpoint         (setpoint_ff),
      .delay_count      (delay_count_ff),
      .equal_mark       (equal_mark_ff),
      .step_size        (step_size),
      .delay_limit      (delay_limit),
      .lower_clamp      (lower_clamp),
      .upper_clamp      (upper_clamp),
      .setpoint_next    (setpoint_in),
      .delay_count_next (delay_count_in),
      .equal_mark_next  (equal_mark_in)
   );

   // Result register. The ramp state is only updated when an item moves into
   // it, so the state registers also serve as the result payload.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff   <= 1'b0;
         setpoint_ff    <= '0;
         delay_count_ff <= '0;
         equal_mark_ff  <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (advance) begin
            setpoint_ff    <= setpoint_in;
            delay_count_ff <= delay_count_in;
            equal_mark_ff  <= equal_mark_in;
         end
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_setpoint_out = setpoint_ff;
   assign rsp_at_target    = equal_mark_ff;

endmodule

// File: rtl/srl_csr.sv
// Configuration registers of the setpoint ramp limiter.
// Depends on srl_pkg for register indexes and the counter type.
module srl_csr
   import srl_pkg::*;
#(
   parameter int VALUE_WIDTH = 16,
   parameter int CSR_WIDTH   = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  csr_index_type                 csr_index,
   input  logic [CSR_WIDTH-1:0]          csr_wdata,
   output logic [VALUE_WIDTH-2:0]        step_size,
   output count_type                     delay_limit,
   output logic signed [VALUE_WIDTH-1:0] lower_clamp,
   output logic signed [VALUE_WIDTH-1:0] upper_clamp
);

   logic [VALUE_WIDTH-2:0]        step_size_ff;
   count_type                     delay_limit_ff;
   logic signed [VALUE_WIDTH-1:0] lower_clamp_ff;
   logic signed [VALUE_WIDTH-1:0] upper_clamp_ff;

   // Register writes; each register takes the low bits of the write data.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_size_ff   <= {{(VALUE_WIDTH-2){1'b0}}, 1'b1};
         delay_limit_ff <= '0;
         lower_clamp_ff <= {1'b1, {(VALUE_WIDTH-1){1'b0}}};
         upper_clamp_ff <= {1'b0, {(VALUE_WIDTH-1){1'b1}}};
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_STEP_SIZE:   step_size_ff   <= csr_wdata[VALUE_WIDTH-2:0];
            REG_DELAY_LIMIT: delay_limit_ff <= csr_wdata[CNT_WIDTH-1:0];
            REG_LOWER_CLAMP: lower_clamp_ff <= csr_wdata[VALUE_WIDTH-1:0];
            REG_UPPER_CLAMP: upper_clamp_ff <= csr_wdata[VALUE_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   assign step_size   = step_size_ff;
   assign delay_limit = delay_limit_ff;
   assign lower_clamp = lower_clamp_ff;
   assign upper_clamp = upper_clamp_ff;

endmodule

// File: rtl/srl_step.sv
// Next-state logic of the setpoint ramp limiter for one item.
// Depends on srl_pkg for the counter type and its maximum value.
module srl_step
   import srl_pkg::*;
#(
   parameter int VALUE_WIDTH = 16
) (
   input  logic signed [VALUE_WIDTH-1:0] target,
   input  logic signed [VALUE_WIDTH-1:0] setpoint,
   input  count_type                     delay_count,
   input  logic                          equal_mark,
   input  logic [VALUE_WIDTH-2:0]        step_size,
   input  count_type                     delay_limit,
   input  logic signed [VALUE_WIDTH-1:0] lower_clamp,
   input  logic signed [VALUE_WIDTH-1:0] upper_clamp,
   output logic signed [VALUE_WIDTH-1:0] setpoint_next,
   output count_type                     delay_count_next,
   output logic                          equal_mark_next
);

   localparam int WIDE = VALUE_WIDTH + 1;

   logic signed [WIDE-1:0] target_w;
   logic signed [WIDE-1:0] setpoint_w;
   logic signed [WIDE-1:0] step_w;
   logic signed [WIDE-1:0] gap;
   logic signed [WIDE-1:0] gap_mag;
   logic signed [WIDE-1:0] down_sum;
   logic signed [WIDE-1:0] up_sum;
   logic signed [VALUE_WIDTH-1:0] down_value;
   logic signed [VALUE_WIDTH-1:0] up_value;
   logic                   gap_neg;
   logic                   gap_zero;
   logic                   ramping;
   logic                   move_down;
   count_type              count_inc;
   logic                   fire;

   // Widen the operands to VALUE_WIDTH+1 bits so that the gap and the sums cannot wrap.
   assign target_w   = {target[VALUE_WIDTH-1], target};
   assign setpoint_w = {setpoint[VALUE_WIDTH-1], setpoint};
   assign step_w     = {2'b00, step_size};

   assign gap      = target_w - setpoint_w;
   assign gap_neg  = gap[WIDE-1];
   assign gap_zero = (gap == '0);
   assign gap_mag  = gap_neg ? -gap : gap;
   assign ramping  = !gap_zero && (gap_mag >= step_w);

   // Direction of a step, with the reverse branches of each side kept in.
   assign move_down = gap_neg ? (target <= setpoint) : !(target >= setpoint);

   // Stepped values, each clamped on its own side only.
   assign down_sum   = setpoint_w - step_w;
   assign up_sum     = setpoint_w + step_w;
   assign down_value = (down_sum < $signed({lower_clamp[VALUE_WIDTH-1], lower_clamp}))
                       ? lower_clamp : down_sum[VALUE_WIDTH-1:0];
   assign up_value   = (up_sum >= $signed({upper_clamp[VALUE_WIDTH-1], upper_clamp}))
                       ? upper_clamp : up_sum[VALUE_WIDTH-1:0];

   // Saturating delay prescaler; a step is due once the count reaches the limit.
   assign count_inc = (delay_count == CNT_MAX) ? delay_count : delay_count + 1'b1;
   assign fire      = (count_inc >= delay_limit);

   // Update of setpoint, delay count and equal mark.
   always_comb begin
      setpoint_next    = setpoint;
      delay_count_next = delay_count;
      equal_mark_next  = equal_mark;
      if (ramping) begin
         equal_mark_next = 1'b0;
         if (fire) begin
            delay_count_next = '0;
            setpoint_next    = move_down ? down_value : up_value;
         end else begin
            delay_count_next = count_inc;
         end
      end else if (!gap_zero) begin
         equal_mark_next = 1'b1;
      end
   end

endmodule

// File: rtl/srl_checker.sv
// Port-level checks for the setpoint ramp limiter, bound to the top level.
// Depends on setpoint_ramp_limiter_top.
module srl_checker #(
   parameter int VALUE_WIDTH = 16
) (
   input logic                                    clock,
   input logic                                    reset,
   input logic                                    req_ready,
   input logic                                    rsp_valid,
   input logic                                    rsp_ready,
   input logic signed [VALUE_WIDTH-1:0]           rsp_setpoint_out,
   input logic                                    rsp_at_target
);

   // No result item is offered straight after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered after reset");

   // A stalled result item keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_setpoint_out)
                                  && $stable(rsp_at_target))
      else $error("stalled result item changed");

   // With the result register empty, a new item is always taken.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled while result register empty");

   // The setpoint only moves on a ramp step, which clears the at-target flag.
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && (rsp_setpoint_out != $past(rsp_setpoint_out)) |-> !rsp_at_target)
      else $error("setpoint moved while at target");

endmodule

bind setpoint_ramp_limiter_top srl_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_srl_checker (.*);

// File: test/setpoint_ramp_limiter_top_tb.sv
// Self-checking testbench for setpoint_ramp_limiter_top: directed and random target items.
// A scoreboard class predicts each result item from its own copy of the ramp state.
// Depends on srl_pkg and the setpoint_ramp_limiter_top RTL.
`timescale 1ns / 1ps

module setpoint_ramp_limiter_top_tb;
   import srl_pkg::*;

   localparam int VW          = 16;
   localparam int WDATA_W     = (VW > CNT_WIDTH) ? VW : CNT_WIDTH;
   localparam int LATENCY     = 2;
   localparam int QUIET_LIMIT = 2000;

   typedef struct {
      logic signed [VW-1:0] setpoint;
      logic                 at_target;
   } ramp_result_type;

   // Predicts the setpoint and at-target flag for each accepted target item
   // and holds the results still to come.
   class ramp_scoreboard;
      logic [VW-2:0]        step_size;
      count_type            delay_limit;
      logic signed [VW-1:0] lower_clamp;
      logic signed [VW-1:0] upper_clamp;
      logic signed [VW-1:0] level;
      count_type            tick_count;
      logic                 near_mark;
      ramp_result_type      expected_q[$];
      int                   errors;

      function new();
         step_size   = 1;
         delay_limit = '0;
         lower_clamp = -32768;
         upper_clamp = 32767;
         level       = '0;
         tick_count  = '0;
         near_mark   = 1'b0;
         errors      = 0;
      endfunction

      function void write_register(csr_index_type idx, logic [WDATA_W-1:0] value);
         case (idx)
            REG_STEP_SIZE:   step_size   = value[VW-2:0];
            REG_DELAY_LIMIT: delay_limit = value[CNT_WIDTH-1:0];
            REG_LOWER_CLAMP: lower_clamp = value[VW-1:0];
            REG_UPPER_CLAMP: upper_clamp = value[VW-1:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Advances the ramp by one tick and queues the result it gives.
      function void note_target(logic signed [VW-1:0] target);
         ramp_result_type want;
         int gap;
         int distance;
         int moved;
         int step;
         gap      = int'(target) - int'(level);
         distance = (gap < 0) ? -gap : gap;
         step     = int'(step_size);
         if (gap != 0) begin
            if (distance >= step) begin
               near_mark = 1'b0;
               if (tick_count != CNT_MAX)
                  tick_count = tick_count + 1'b1;
               if (tick_count >= delay_limit) begin
                  tick_count = '0;
                  // A step always moves toward the target; the clamp on that side applies.
                  if (gap < 0) begin
                     moved = int'(level) - step;
                     if (moved < int'(lower_clamp))
                        moved = int'(lower_clamp);
                  end else begin
                     moved = int'(level) + step;
                     if (moved >= int'(upper_clamp))
                        moved = int'(upper_clamp);
                  end
                  level = moved[VW-1:0];
               end
            end else begin
               near_mark = 1'b1;
            end
         end
         want.setpoint  = level;
         want.at_target = near_mark;
         expected_q.push_back(want);
      endfunction

      // Compares one result item with the oldest expectation.
      function void check_result(logic signed [VW-1:0] setpoint, logic at_target);
         ramp_result_type want;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: result with none expected: setpoint %0d at_target %0b",
                     $time, setpoint, at_target);
            return;
         end
         want = expected_q.pop_front();
         if (setpoint !== want.setpoint) begin
            errors++;
            $display("%0t: setpoint_out mismatch: expected %0d actual %0d",
                     $time, want.setpoint, setpoint);
         end
         if (at_target !== want.at_target) begin
            errors++;
            $display("%0t: at_target mismatch: expected %0b actual %0b",
                     $time, want.at_target, at_target);
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic signed [VW-1:0] req_target_in;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic signed [VW-1:0] rsp_setpoint_out;
   logic                 rsp_at_target;
   logic                 csr_wr_en;
   csr_index_type        csr_index;
   logic [WDATA_W-1:0]   csr_wdata;

   ramp_scoreboard board = new();
   int send_idle_pct;
   int stall_pct;

   setpoint_ramp_limiter_top #(
      .VALUE_WIDTH(VW)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_target_in    (req_target_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_setpoint_out (rsp_setpoint_out),
      .rsp_at_target    (rsp_at_target),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // The receiver stalls at random according to the current phase.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // Both handshakes are sampled at the edge, before any update of that edge lands.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            board.note_target(req_target_in);
         if (rsp_valid && rsp_ready)
            board.check_result(rsp_setpoint_out, rsp_at_target);
      end
   end

   // Ends the run when nothing has been accepted on either channel for too long.
   always @(posedge clock) begin : watchdog
      int quiet;
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet = 0;
      else
         quiet++;
      if (quiet >= QUIET_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
         $display("setpoint_ramp_limiter_top test failed");
         $finish;
      end
   end

   // Offers one target item and returns at the edge where it is accepted.
   // Valid is left high so that back-to-back items need no second assignment.
   task automatic send_target(input logic signed [VW-1:0] target);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_target_in <= target;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   // Stops sending and waits until every expected result item has arrived.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0)
         @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [WDATA_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      board.write_register(idx, value);
      @(posedge clock);
   endtask

   // Writes all four registers; the block must be idle. The unused top bit of
   // the step write is random, as the register drops it.
   task automatic apply_settings(input logic [VW-2:0] step, input count_type limit,
                                 input logic signed [VW-1:0] lo,
                                 input logic signed [VW-1:0] hi);
      write_register(REG_STEP_SIZE, {1'($urandom_range(1)), step});
      write_register(REG_DELAY_LIMIT, limit);
      write_register(REG_LOWER_CLAMP, lo);
      write_register(REG_UPPER_CLAMP, hi);
      csr_wr_en <= 1'b0;
   endtask

   // Picks a register setting at random, extremes included.
   task automatic random_settings();
      logic [VW-2:0]        step;
      count_type            limit;
      logic signed [VW-1:0] a;
      logic signed [VW-1:0] b;
      case ($urandom_range(5))
         0: step = '0;
         1: step = 1;
         2: step = '1;
         3: step = (VW-1)'($urandom_range(2, 64));
         4: step = (VW-1)'($urandom_range(65, 4096));
         default: step = (VW-1)'($urandom);
      endcase
      case ($urandom_range(3))
         0: limit = '0;
         1: limit = 1;
         2: limit = CNT_WIDTH'($urandom_range(2, 4));
         default: limit = CNT_WIDTH'($urandom_range(5, 12));
      endcase
      a = VW'($urandom);
      b = VW'($urandom);
      case ($urandom_range(3))
         0: apply_settings(step, limit, -32768, 32767);
         1: apply_settings(step, limit, (a < b) ? a : b, (a < b) ? b : a);
         2: apply_settings(step, limit, (a < b) ? b : a, (a < b) ? a : b);
         default: apply_settings(step, limit, VW'(-int'($urandom_range(1, 3000))),
                                 VW'($urandom_range(1, 3000)));
      endcase
   endtask

   // Random part: mostly a target held for a run of ticks so the setpoint ramps
   // toward it and settles, with noise items in between.
   task automatic run_bursts(input int count, input bit pause_midway);
      int                   sent;
      int                   hold;
      int                   span;
      int                   goal;
      logic signed [VW-1:0] target;
      sent = 0;
      while (sent < count) begin
         hold = $urandom_range(1, 40);
         case ($urandom_range(9))
            0, 1: goal = int'($signed(VW'($urandom)));
            2: begin
               case ($urandom_range(3))
                  0: goal = -32768;
                  1: goal = 32767;
                  2: goal = int'(board.lower_clamp);
                  default: goal = int'(board.upper_clamp);
               endcase
            end
            8, 9: begin
               goal = int'($signed(VW'($urandom)));
               hold = 1;
            end
            default: begin
               span = int'(board.step_size) * $urandom_range(1, 12) + $urandom_range(0, 3);
               goal = int'(board.level) + $urandom_range(0, 2 * span) - span;
               if (goal > 32767)
                  goal = 32767;
               if (goal < -32768)
                  goal = -32768;
            end
         endcase
         target = goal[VW-1:0];
         repeat (hold) begin
            if (sent < count) begin
               send_target(target);
               sent++;
               if (pause_midway && sent == count / 2)
                  drain();
            end
         end
      end
   endtask

   initial begin : stimulus
      int send_modes[4];
      int stall_modes[4];
      send_modes  = '{0, 71, 0, 13};
      stall_modes = '{0, 0, 71, 13};
      send_idle_pct = 0;
      stall_pct     = 0;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_target_in <= '0;
      csr_wr_en     <= 1'b0;
      csr_index     <= REG_STEP_SIZE;
      csr_wdata     <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Equal values, a gap below one step, then full-scale ramps each way.
      apply_settings(256, 0, -32768, 32767);
      send_target(0);
      send_target(5);
      send_target(5);
      send_target(-3);
      send_target(32767);
      send_target(32767);
      send_target(-32768);
      send_target(-32768);
      send_target(-32768);
      drain();

      // A zero step ramps by nothing on every nonzero gap.
      apply_settings(0, 1, -32768, 32767);
      send_target(7);
      send_target(-7);
      send_target(0);
      drain();

      // Crossed clamps with the largest step: each side clamps on its own, and
      // the setpoint is left outside the clamps between steps.
      apply_settings('1, 2, 1000, -1000);
      send_target(32767);
      send_target(32767);
      send_target(32767);
      send_target(-32768);
      send_target(-32768);
      send_target(-32768);
      send_target(0);
      drain();

      // The largest delay limit: the count rises but no step is reached.
      apply_settings(100, '1, -32768, 32767);
      send_target(32767);
      send_target(32767);
      send_target(-32768);
      drain();

      for (int phase = 0; phase < 8; phase++) begin
         random_settings();
         send_idle_pct = send_modes[phase % 4];
         stall_pct     = stall_modes[phase % 4];
         run_bursts(200, phase == 5);
         drain();
      end

      if (board.errors == 0 && board.pending() == 0)
         $display("setpoint_ramp_limiter_top test passed");
      else
         $display("setpoint_ramp_limiter_top test failed");
      $finish;
   end

endmodule
